@@ sv/priority_schedule_wait_times_assert.svh @@
// Assertion macros for the priority scheduler block.
// Used by the top level only; no other dependencies.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_ASSERT_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_ASSERT_SVH

// same-cycle implication
`define PSW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psw check failed");

// next-cycle implication
`define PSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psw check failed");

`endif

@@ sv/psw_pkg.sv @@
// Package for the priority scheduler: record layout, widths, defaults.
// No dependencies.
package psw_pkg;

   localparam int MAX_PROCS_DEF = 16;

   localparam int REC_W   = 48;
   localparam int WAIT_W  = 21;
   localparam int SUMW_W  = 25;
   localparam int SUMT_W  = 20;
   localparam int RSP_W   = 120;

   // stored record, process number in the lowest bits (same as req_tdata)
   typedef struct packed {
      logic [15:0] arrive;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [7:0]  pid;
   } rec_type;

   // run order: lower priority value first, then earlier arrival
   function automatic logic runs_first(input rec_type a, input rec_type b);
      logic res;
      res = (a.prio < b.prio) || ((a.prio == b.prio) && (a.arrive < b.arrive));
      return res;
   endfunction

endpackage

@@ sv/psw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module psw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/priority_schedule_wait_times.sv @@
// Non-preemptive priority scheduler: computes per-process wait times.
// Depends on psw_pkg, psw_ram and priority_schedule_wait_times_assert.svh.
//
//  channel | dir | tdata fields (low bit up)                          | tlast / tuser
//  req     | in  | proc_id, burst_len, prio, arrive_at                | last_record / -
//  rsp     | out | out_proc_id, out_burst, out_prio, out_arrival,     | final_result / dropped
//          |     | wait_ticks, sum_wait, sum_time, 6 bits zero pad    |
//
// Loading takes one word per cycle into the record RAM.
// After the closing word the set is ordered by repeated scans of the record RAM:
// each scan reads all n entries, n scans for the run order, then n scans for
// output order, each output scan followed by a send state that waits out any stall.
// Input is taken again once the last word has gone into the output register.
// Reset is synchronous; RAM contents are not cleared. Output stalls hold the scan.
`include "priority_schedule_wait_times_assert.svh"

module priority_schedule_wait_times #(
   parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [47:0]              req_tdata,  // proc_id, burst_len, prio, arrive_at
   input  logic                     req_tlast,  // last_record
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_proc_id, out_burst, out_prio, out_arrival, wait_ticks, sum_wait, sum_time
   output logic [psw_pkg::RSP_W-1:0] rsp_tdata,
   output logic                     rsp_tlast,  // final_result
   output logic                     rsp_tuser   // dropped
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int PAD_W = psw_pkg::RSP_W - 48 - psw_pkg::WAIT_W - psw_pkg::SUMW_W
                          - psw_pkg::SUMT_W;

   typedef enum logic [1:0] {
      LOAD,
      RUN_SCAN,
      OUT_SCAN,
      OUT_SEND
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             have_ff, have_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   psw_pkg::rec_type best_rec_ff, best_rec_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [psw_pkg::SUMW_W-1:0] start_ff, start_in;
   logic [psw_pkg::SUMW_W-1:0] sumw_ff, sumw_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [psw_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_drop_ff, rsp_drop_in;

   logic                       rec_we;
   logic [psw_pkg::REC_W-1:0]  rec_rdata;
   psw_pkg::rec_type           cand;
   logic                       wait_we;
   logic [psw_pkg::WAIT_W-1:0] wait_rdata;
   logic [psw_pkg::SUMW_W-1:0] diff;
   logic                       req_acc;
   logic                       scan_end;
   logic                       cand_better;
   logic                       slot_free;
   logic                       last_pass;

   // record and wait memories
   psw_ram #(.WIDTH(psw_pkg::REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rec_rdata)
   );

   psw_ram #(.WIDTH(psw_pkg::WAIT_W), .DEPTH(MAX_PROCS)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wait_we),
      .wr_addr (best_idx_ff),
      .wr_data (diff[psw_pkg::WAIT_W-1:0]),
      .rd_addr (best_idx_ff),
      .rd_data (wait_rdata)
   );

   assign cand      = psw_pkg::rec_type'(rec_rdata);
   assign req_tready = (state_ff == LOAD);
   assign req_acc   = req_tvalid && req_tready;
   assign rec_we    = req_acc && (cnt_ff < CNT_W'(MAX_PROCS));
   assign scan_end  = (iss_ff == cnt_ff) && !cmp_vld_ff;
   assign diff      = start_ff - {{(psw_pkg::SUMW_W-16){1'b0}}, best_rec_ff.arrive};
   assign wait_we   = (state_ff == RUN_SCAN) && scan_end;
   assign slot_free = !rsp_vld_ff || rsp_tready;
   assign last_pass = ((pass_ff + CNT_W'(1)) == cnt_ff);

   // candidate against current best, per scan kind
   always_comb begin
      if (state_ff == RUN_SCAN) begin
         cand_better = psw_pkg::runs_first(cand, best_rec_ff);
      end else begin
         cand_better = cand.pid < best_rec_ff.pid;
      end
   end

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      pass_in     = pass_ff;
      iss_in      = iss_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = iss_ff[IDX_W-1:0];
      have_in     = have_ff;
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      done_in     = done_ff;
      start_in    = start_ff;
      sumw_in     = sumw_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_drop_in = rsp_drop_ff;

      // scan: issue reads, compare returned entries
      if ((state_ff == RUN_SCAN) || (state_ff == OUT_SCAN)) begin
         if (iss_ff != cnt_ff) begin
            iss_in     = iss_ff + CNT_W'(1);
            cmp_vld_in = 1'b1;
         end
         if (cmp_vld_ff && !done_ff[cmp_idx_ff] && (!have_ff || cand_better)) begin
            have_in     = 1'b1;
            best_idx_in = cmp_idx_ff;
            best_rec_in = cand;
         end
      end

      unique case (state_ff)
         LOAD: begin
            if (req_acc) begin
               if (rec_we) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = RUN_SCAN;
                  iss_in   = '0;
                  pass_in  = '0;
                  have_in  = 1'b0;
                  done_in  = '0;
                  start_in = '0;
                  sumw_in  = '0;
               end
            end
         end
         RUN_SCAN: begin
            if (scan_end) begin
               start_in = start_ff + {{(psw_pkg::SUMW_W-16){1'b0}}, best_rec_ff.burst};
               sumw_in  = sumw_ff + diff;
               done_in[best_idx_ff] = 1'b1;
               iss_in   = '0;
               have_in  = 1'b0;
               if (last_pass) begin
                  state_in = OUT_SCAN;
                  pass_in  = '0;
                  done_in  = '0;
               end else begin
                  pass_in = pass_ff + CNT_W'(1);
               end
            end
         end
         OUT_SCAN: begin
            if (scan_end) begin
               done_in[best_idx_ff] = 1'b1;
               state_in = OUT_SEND;
            end
         end
         OUT_SEND: begin
            if (slot_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = last_pass;
               rsp_drop_in = ovf_ff;
               rsp_data_in = {{PAD_W{1'b0}},
                              (last_pass ? start_ff[psw_pkg::SUMT_W-1:0]
                                         : {psw_pkg::SUMT_W{1'b0}}),
                              (last_pass ? sumw_ff : {psw_pkg::SUMW_W{1'b0}}),
                              wait_rdata,
                              best_rec_ff};
               iss_in  = '0;
               have_in = 1'b0;
               if (last_pass) begin
                  state_in = LOAD;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in = OUT_SCAN;
                  pass_in  = pass_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = LOAD;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOAD;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         pass_ff    <= '0;
         iss_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         have_ff    <= 1'b0;
         done_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         pass_ff    <= pass_in;
         iss_ff     <= iss_in;
         cmp_vld_ff <= cmp_vld_in;
         have_ff    <= have_in;
         done_ff    <= done_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      start_ff    <= start_in;
      sumw_ff     <= sumw_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

   // checks
   `PSW_ASSERT_NOW(a_cnt_max, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_PROCS))
   `PSW_ASSERT_NOW(a_iss_range, clock, reset, 1'b1, iss_ff <= cnt_ff)
   `PSW_ASSERT_NOW(a_load_idle, clock, reset, req_tready, !cmp_vld_ff)
   `PSW_ASSERT_NEXT(a_set_close, clock, reset,
      (state_ff == OUT_SEND) && slot_free && last_pass, (cnt_ff == '0) && rsp_tlast)

endmodule

@@ bench/priority_schedule_wait_times_test.sv @@
// Self-checking bench for the priority scheduler: drives record sets, predicts wait times.
// Depends on psw_pkg and the priority_schedule_wait_times top level.
module priority_schedule_wait_times_test;

   localparam int NPROC = psw_pkg::MAX_PROCS_DEF;

   typedef struct packed {
      logic [47:0] data;
      logic        last;
   } req_word_type;

   typedef struct {
      logic [7:0]                  pid;
      logic [15:0]                 burst;
      logic [7:0]                  prio;
      logic [15:0]                 arrive;
      logic [psw_pkg::WAIT_W-1:0]  wait_t;
      logic [psw_pkg::SUMW_W-1:0]  sum_w;
      logic [psw_pkg::SUMT_W-1:0]  sum_t;
      logic                        dropped;
      logic                        fin;
   } sched_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [psw_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   req_word_type     pending_words[$];
   sched_rec_type    expected_recs[$];
   psw_pkg::rec_type loaded[NPROC];
   int               loaded_n = 0;
   logic             overflowed = 1'b0;
   int               fail_count = 0;
   bit               stim_done;

   priority_schedule_wait_times dut (.*);

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // work out the results of a closed set and queue them
   task automatic schedule_set();
      int run_ord[NPROC];
      int out_ord[NPROC];
      logic [psw_pkg::WAIT_W-1:0] waits[NPROC];
      longint start_t, tot_w, tot_t;
      int i, j, k;
      sched_rec_type r;
      start_t = 0;
      tot_w = 0;
      tot_t = 0;
      for (i = 0; i < loaded_n; i++) begin
         j = i;
         while (j > 0 && ((loaded[i].prio < loaded[run_ord[j-1]].prio) ||
                ((loaded[i].prio == loaded[run_ord[j-1]].prio) &&
                 (loaded[i].arrive < loaded[run_ord[j-1]].arrive)))) begin
            run_ord[j] = run_ord[j-1];
            j--;
         end
         run_ord[j] = i;
      end
      for (i = 0; i < loaded_n; i++) begin
         k = run_ord[i];
         waits[k] = psw_pkg::WAIT_W'(start_t - longint'(loaded[k].arrive));
         tot_w += start_t - longint'(loaded[k].arrive);
         start_t += loaded[k].burst;
         tot_t += loaded[k].burst;
      end
      for (i = 0; i < loaded_n; i++) begin
         j = i;
         while (j > 0 && loaded[i].pid < loaded[out_ord[j-1]].pid) begin
            out_ord[j] = out_ord[j-1];
            j--;
         end
         out_ord[j] = i;
      end
      for (i = 0; i < loaded_n; i++) begin
         k = out_ord[i];
         r.pid = loaded[k].pid;
         r.burst = loaded[k].burst;
         r.prio = loaded[k].prio;
         r.arrive = loaded[k].arrive;
         r.wait_t = waits[k];
         r.fin = (i == loaded_n - 1);
         r.sum_w = r.fin ? psw_pkg::SUMW_W'(tot_w) : '0;
         r.sum_t = r.fin ? psw_pkg::SUMT_W'(tot_t) : '0;
         r.dropped = overflowed;
         expected_recs.push_back(r);
      end
      loaded_n = 0;
      overflowed = 1'b0;
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic req_word_type make_word(int pid, int burst, int prio, int arr, bit last);
      req_word_type w;
      w.data = {16'(arr), 8'(prio), 16'(burst), 8'(pid)};
      w.last = last;
      return w;
   endfunction

   // stimulus: directed sets, then random sets
   initial begin
      int n, i, sent, pr_span, ar_span;
      for (i = 0; i < 3; i++)
         @(posedge clock);
      // single record, extremes
      pending_words.push_back(make_word(255, 65535, 255, 65535, 1));
      pending_words.push_back(make_word(0, 1, 0, 0, 1));
      // equal priorities and arrivals, duplicate process numbers
      pending_words.push_back(make_word(7, 65535, 5, 0, 0));
      pending_words.push_back(make_word(7, 65535, 5, 0, 0));
      pending_words.push_back(make_word(3, 2, 5, 100, 0));
      pending_words.push_back(make_word(3, 1, 0, 65535, 1));
      // overflow: capacity plus two, closing word dropped
      for (i = 0; i < NPROC + 2; i++)
         pending_words.push_back(make_word(255 - i, 65535, 255 - (i % 3), i * 4000,
                                           i == NPROC + 1));
      sent = pending_words.size();
      // random sets, mostly small, a few full or overflowing
      while (sent < 220) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(NPROC, NPROC + 3)
                                         : $urandom_range(1, 6);
         pr_span = $urandom_range(0, 1) ? 3 : 255;
         ar_span = $urandom_range(0, 1) ? 4 : 65535;
         for (i = 0; i < n; i++)
            pending_words.push_back(make_word($urandom_range(0, 255),
               $urandom_range(0, 3) == 0 ? 65535 - $urandom_range(0, 3)
                                         : $urandom_range(1, 65535),
               $urandom_range(0, pr_span), $urandom_range(0, ar_span), i == n - 1));
         sent += n;
      end
      stim_done = 1'b1;
   end

   // reset
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: one word at a time with a random gap before each
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (loaded_n < NPROC) begin
               loaded[loaded_n] = psw_pkg::rec_type'(req_tdata);
               loaded_n++;
            end else begin
               overflowed = 1'b1;
            end
            if (req_tlast)
               schedule_set();
            void'(pending_words.pop_front());
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end
         if (req_tvalid && !req_tready) begin
            // hold the word
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_words[0].data;
            req_tlast  <= pending_words[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: checks each result word, stalls at random
   int stall_left = 0;
   always @(posedge clock) begin
      sched_rec_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_recs.size() == 0) begin
               report("unexpected word", rsp_tdata[63:0], 0);
            end else begin
               e = expected_recs.pop_front();
               if (rsp_tdata[7:0] != e.pid) report("proc_id", rsp_tdata[7:0], e.pid);
               if (rsp_tdata[23:8] != e.burst) report("burst", rsp_tdata[23:8], e.burst);
               if (rsp_tdata[31:24] != e.prio) report("prio", rsp_tdata[31:24], e.prio);
               if (rsp_tdata[47:32] != e.arrive)
                  report("arrival", rsp_tdata[47:32], e.arrive);
               if (rsp_tdata[68:48] != e.wait_t) report("wait", rsp_tdata[68:48], e.wait_t);
               if (rsp_tdata[93:69] != e.sum_w) report("sum_wait", rsp_tdata[93:69], e.sum_w);
               if (rsp_tdata[113:94] != e.sum_t)
                  report("sum_time", rsp_tdata[113:94], e.sum_t);
               if (rsp_tuser != e.dropped) report("dropped", rsp_tuser, e.dropped);
               if (rsp_tlast != e.fin) report("final", rsp_tlast, e.fin);
            end
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (pending_words.size() != 0 || expected_recs.size() != 0)
         @(posedge clock);
      repeat (2 * NPROC * (NPROC + 3) + 50) @(posedge clock);
      if (fail_count == 0)
         $display("[priority_schedule_wait_times] OK");
      else
         $display("[priority_schedule_wait_times] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 3000000);
      $display("[priority_schedule_wait_times] ERROR");
      $finish;
   end

endmodule
